@@ src/lprd_pkg.sv @@
package lprd_pkg;

  localparam int unsigned HdrBytes = 4;
  localparam int unsigned HdrIdxW  = $clog2(HdrBytes);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_PADDING = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OC_CONT  = 3'd0,
    OC_OK    = 3'd1,
    OC_TRUNC = 3'd2,
    OC_ZERO  = 3'd3,
    OC_SKIP  = 3'd4
  } outcome_t;

endpackage

@@ src/lprd_if.sv @@
interface lprd_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       section_end;

  modport source (output valid, data_byte, section_end, input ready);
  modport sink (input valid, data_byte, section_end, output ready);
endinterface

interface lprd_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        record_first;
  logic        record_last;
  logic [31:0] record_offset;
  logic [2:0]  outcome;

  modport source (output valid, payload_byte, payload_valid, record_first, record_last,
                  record_offset, outcome, input ready);
  modport sink (input valid, payload_byte, payload_valid, record_first, record_last,
                record_offset, outcome, output ready);
endinterface

@@ src/length_prefixed_record_deframer.sv @@
// the result for a byte is registered when the byte is accepted
// throughput: one byte per cycle unless rec_chan stalls; frame state updates per byte
// the result register is taken while a new byte is accepted, so stalls cost no bubble
// reset (rst, synchronous): frame state back to header phase at offset zero,
// result register emptied
module length_prefixed_record_deframer (
  input  logic                clk,
  input  logic                rst,
  lprd_in_if.sink             byte_chan,
  lprd_out_if.source          rec_chan
);

  lprd_pkg::phase_t                 phase, phase_next;
  logic [lprd_pkg::HdrIdxW-1:0]     hdr_seen, hdr_seen_next;
  logic [31:0]                      length_acc, length_acc_next;
  logic [31:0]                      remaining, remaining_next;
  logic [31:0]                      byte_position, byte_position_next;
  logic [31:0]                      record_start, record_start_next;
  logic                             hdr_nonzero, hdr_nonzero_next;

  logic                             accept;
  logic [7:0]                       b;
  logic                             last_in;
  logic                             new_hdr;
  logic [31:0]                      acc_base;
  logic [31:0]                      remaining_dec;

  logic [7:0]                       pbyte_next;
  logic                             pvalid_next, first_next, last_next;
  lprd_pkg::outcome_t               outcome_next;

  logic                             out_valid;
  logic [7:0]                       pbyte;
  logic                             pvalid, first, last;
  logic [31:0]                      offset;
  lprd_pkg::outcome_t               outcome;

  assign byte_chan.ready = !out_valid || rec_chan.ready;
  assign accept          = byte_chan.valid && byte_chan.ready;
  assign b               = byte_chan.data_byte;
  assign last_in         = byte_chan.section_end;
  assign new_hdr         = (hdr_seen == '0);
  assign acc_base        = new_hdr ? 32'd0 : length_acc;
  assign remaining_dec   = remaining - 32'd1;

  always_comb begin
    phase_next         = phase;
    hdr_seen_next      = hdr_seen;
    length_acc_next    = length_acc;
    remaining_next     = remaining;
    record_start_next  = record_start;
    hdr_nonzero_next   = hdr_nonzero;
    byte_position_next = byte_position + 32'd1;
    pbyte_next         = 8'd0;
    pvalid_next        = 1'b0;
    first_next         = 1'b0;
    last_next          = 1'b0;
    outcome_next       = lprd_pkg::OC_CONT;
    unique case (phase)
      lprd_pkg::PH_PAYLOAD: begin
        pvalid_next    = 1'b1;
        pbyte_next     = b;
        first_next     = (remaining == length_acc);
        remaining_next = remaining_dec;
        if (remaining_dec == 32'd0) begin
          last_next     = 1'b1;
          phase_next    = lprd_pkg::PH_HEADER;
          hdr_seen_next = '0;
          outcome_next  = last_in ? lprd_pkg::OC_OK : lprd_pkg::OC_CONT;
        end else begin
          outcome_next  = last_in ? lprd_pkg::OC_TRUNC : lprd_pkg::OC_CONT;
        end
      end
      lprd_pkg::PH_PADDING: begin
        if (b != 8'd0) begin
          outcome_next = lprd_pkg::OC_ZERO;
          phase_next   = lprd_pkg::PH_SKIP;
        end else begin
          outcome_next = last_in ? lprd_pkg::OC_OK : lprd_pkg::OC_CONT;
        end
      end
      lprd_pkg::PH_SKIP: begin
        outcome_next = lprd_pkg::OC_SKIP;
      end
      lprd_pkg::PH_HEADER: begin
        if (new_hdr) begin
          record_start_next = byte_position;
        end
        length_acc_next  = acc_base | ({24'd0, b} << {hdr_seen, 3'b000});
        hdr_nonzero_next = (!new_hdr && hdr_nonzero) || (b != 8'd0);
        // little-endian length: last header byte completes the record header
        if (hdr_seen != lprd_pkg::HdrIdxW'(lprd_pkg::HdrBytes - 1)) begin
          hdr_seen_next = hdr_seen + 1'b1;
          if (last_in) begin
            outcome_next = hdr_nonzero_next ? lprd_pkg::OC_TRUNC : lprd_pkg::OC_OK;
          end
        end else begin
          hdr_seen_next = '0;
          if (length_acc_next == 32'd0) begin
            phase_next   = lprd_pkg::PH_PADDING;
            outcome_next = last_in ? lprd_pkg::OC_OK : lprd_pkg::OC_CONT;
          end else if (last_in) begin
            outcome_next = lprd_pkg::OC_TRUNC;
          end else begin
            phase_next     = lprd_pkg::PH_PAYLOAD;
            remaining_next = length_acc_next;
          end
        end
      end
      default: begin
        phase_next = lprd_pkg::PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lprd_pkg::PH_HEADER;
      hdr_seen      <= '0;
      length_acc    <= '0;
      remaining     <= '0;
      byte_position <= '0;
      record_start  <= '0;
      hdr_nonzero   <= 1'b0;
    end else if (accept) begin
      if (last_in) begin
        // section end: all frame state returns to its reset value
        phase         <= lprd_pkg::PH_HEADER;
        hdr_seen      <= '0;
        length_acc    <= '0;
        remaining     <= '0;
        byte_position <= '0;
        record_start  <= '0;
        hdr_nonzero   <= 1'b0;
      end else begin
        phase         <= phase_next;
        hdr_seen      <= hdr_seen_next;
        length_acc    <= length_acc_next;
        remaining     <= remaining_next;
        byte_position <= byte_position_next;
        record_start  <= record_start_next;
        hdr_nonzero   <= hdr_nonzero_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rec_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pbyte   <= pbyte_next;
      pvalid  <= pvalid_next;
      first   <= first_next;
      last    <= last_next;
      offset  <= record_start_next;
      outcome <= outcome_next;
    end
  end

  assign rec_chan.valid         = out_valid;
  assign rec_chan.payload_byte  = pbyte;
  assign rec_chan.payload_valid = pvalid;
  assign rec_chan.record_first  = first;
  assign rec_chan.record_last   = last;
  assign rec_chan.record_offset = offset;
  assign rec_chan.outcome       = outcome;

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_in |=> phase == lprd_pkg::PH_HEADER && byte_position == 32'd0
                          && hdr_seen == '0)
    else $error("state not cleared after section end");

  a_payload_pending: assert property (@(posedge clk) disable iff (rst)
    phase == lprd_pkg::PH_PAYLOAD |-> remaining != 32'd0 && hdr_seen == '0)
    else $error("payload phase with nothing left or header in progress");

  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> byte_chan.ready)
    else $error("input stalled with empty result register");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    accept && !last_in |=> byte_position == $past(byte_position) + 32'd1)
    else $error("byte offset did not advance");

endmodule
